### design/tcw_pkg.sv
// Shared types, constants and helpers of the text console cell writer.
// Depends on nothing; used by tcw_screen_ram and text_console_cell_writer.
package tcw_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int CELL_AW        = $clog2(CELL_COUNT);
	localparam int COL_W          = 7;
	localparam int ROW_W          = 5;

	localparam logic [7:0] BLANK_CHAR     = 8'h20;
	localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
	localparam logic [7:0] BLANK_IN_PLACE = 8'h08;
	localparam logic [7:0] ERROR_CHAR     = 8'h45;

	localparam logic [7:0] DEFAULT_ATTR_RESET = 8'h0F;
	localparam logic [7:0] FILL_ATTR_RESET    = 8'h07;
	localparam logic [7:0] ERROR_ATTR_RESET   = 8'hF4;

	localparam logic [1:0] CFG_DEFAULT_ATTR = 2'd0;
	localparam logic [1:0] CFG_FILL_ATTR    = 2'd1;
	localparam logic [1:0] CFG_ERROR_ATTR   = 2'd2;

	typedef logic [CELL_AW-1:0] addr_t;
	typedef logic [15:0] cell_t;

	typedef enum logic [1:0] {
		REQ_PRINT     = 2'd0,
		REQ_BACKSPACE = 2'd1,
		REQ_CLEAR     = 2'd2,
		REQ_READ      = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t        req_type;
		logic [7:0]       char_code;
		logic [7:0]       attribute;
		logic             at_position;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] line;
	} req_t;

	typedef struct packed {
		logic [COL_W-1:0] cursor_column;
		logic [ROW_W-1:0] cursor_line;
		logic [7:0]       cell_char;
		logic [7:0]       cell_attribute;
		logic             out_of_range;
		logic             scrolled;
	} rsp_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		cell_t wdata;
		logic  re;
		addr_t raddr;
	} ram_cmd_t;

	function automatic addr_t cell_addr(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
		return addr_t'(row) * addr_t'(SCREEN_COLUMNS) + addr_t'(col);
	endfunction

	function automatic cell_t make_cell(logic [7:0] ch, logic [7:0] attr);
		return {attr, ch};
	endfunction

endpackage

### design/tcw_screen_ram.sv
// Screen cell memory: one write port and one read port, read data registered.
// Depends on tcw_pkg for the depth, address and cell types.
module tcw_screen_ram (
	input  logic              clk,
	input  tcw_pkg::ram_cmd_t cmd,
	output tcw_pkg::cell_t    rdata
);

	tcw_pkg::cell_t mem [tcw_pkg::CELL_COUNT];

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		if (cmd.re) begin
			rdata <= mem[cmd.raddr];
		end
	end

endmodule

### design/text_console_cell_writer.sv
// Top level of the text console cell writer: request sequencer, cursor and
// configuration registers around the screen cell memory in tcw_screen_ram.
// Depends on tcw_pkg.
//
//   port group                      | dir | role
//   req_valid / req_ready / req_data | in  | one request per beat
//   rsp_valid / rsp_ready / rsp_data | out | one response per request
//   cfg_we / cfg_index / cfg_data    | in  | attribute register writes
//
// A print that scrolls and a clear both walk over the cell memory. After
// reset a clearing pass writes one cell a cycle over all CELL_COUNT (2000)
// cells with req_ready low; configuration writes are taken meanwhile.
// A finished response waits in the output register; a second one waits in a
// holding register until the first beat has gone.
module text_console_cell_writer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tcw_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tcw_pkg::rsp_t  rsp_data,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [7:0]     cfg_data
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL,
		ST_BLANK,
		ST_WAIT_OUT
	} state_t;

	state_t state_q;

	tcw_pkg::req_t  req_q;
	tcw_pkg::rsp_t  rsp_q;
	tcw_pkg::rsp_t  res_q;
	tcw_pkg::rsp_t  fin;
	logic           rsp_valid_q;

	logic [7:0] default_attr_q;
	logic [7:0] fill_attr_q;
	logic [7:0] error_attr_q;

	logic [tcw_pkg::COL_W-1:0] cur_col_q, cur_col_d;
	logic [tcw_pkg::ROW_W-1:0] cur_row_q, cur_row_d;

	tcw_pkg::addr_t cnt_q;
	tcw_pkg::addr_t blk_addr_q;
	logic [7:0]     blk_attr_q;
	logic           scr_q;
	logic           cp_valid_s1;
	tcw_pkg::addr_t cp_addr_s1;

	tcw_pkg::ram_cmd_t ram_cmd;
	tcw_pkg::cell_t    ram_rdata;

	logic       fin_now;
	logic       go_scroll;
	logic       go_clear;
	logic       go_read;
	logic       out_free;
	logic [7:0] fin_char;
	logic [7:0] fin_attr;
	logic       fin_oor;
	logic       fin_scr;

	logic [7:0]                eff_attr;
	logic                      off_screen;
	logic [tcw_pkg::COL_W-1:0] base_col;
	logic [tcw_pkg::ROW_W-1:0] base_row;
	logic [tcw_pkg::ROW_W:0]   next_row;
	tcw_pkg::addr_t            base_addr;

	tcw_screen_ram u_ram (
		.clk   (clk),
		.cmd   (ram_cmd),
		.rdata (ram_rdata)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign eff_attr   = (req_q.attribute == 8'd0) ? default_attr_q : req_q.attribute;
	assign off_screen = ({1'b0, req_q.column} >= (tcw_pkg::COL_W + 1)'(tcw_pkg::SCREEN_COLUMNS))
		|| ({1'b0, req_q.line} >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::SCREEN_ROWS));
	assign base_col   = req_q.at_position ? req_q.column : cur_col_q;
	assign base_row   = req_q.at_position ? req_q.line : cur_row_q;
	assign base_addr  = tcw_pkg::cell_addr(base_row, base_col);

	always_comb begin
		ram_cmd   = '0;
		cur_col_d = cur_col_q;
		cur_row_d = cur_row_q;
		fin_now   = 1'b0;
		go_scroll = 1'b0;
		go_clear  = 1'b0;
		go_read   = 1'b0;
		fin_char  = 8'd0;
		fin_attr  = 8'd0;
		fin_oor   = 1'b0;
		fin_scr   = 1'b0;
		next_row  = '0;
		case (state_q)
			ST_INIT: begin
				ram_cmd.we    = 1'b1;
				ram_cmd.waddr = blk_addr_q;
				ram_cmd.wdata = tcw_pkg::make_cell(tcw_pkg::BLANK_CHAR,
					tcw_pkg::DEFAULT_ATTR_RESET);
			end
			ST_EXEC: begin
				case (req_q.req_type)
					tcw_pkg::REQ_PRINT: begin
						if (req_q.at_position && off_screen) begin
							ram_cmd.we    = 1'b1;
							ram_cmd.waddr = tcw_pkg::addr_t'(tcw_pkg::CELL_COUNT - 1);
							ram_cmd.wdata = tcw_pkg::make_cell(tcw_pkg::ERROR_CHAR,
								error_attr_q);
							fin_oor       = 1'b1;
						end else begin
							cur_col_d = base_col;
							next_row  = {1'b0, base_row};
							if (req_q.char_code == tcw_pkg::NEWLINE_CHAR) begin
								cur_col_d = '0;
								next_row  = {1'b0, base_row} + 1'b1;
							end else if (req_q.char_code == tcw_pkg::BLANK_IN_PLACE) begin
								ram_cmd.we    = 1'b1;
								ram_cmd.waddr = base_addr;
								ram_cmd.wdata = tcw_pkg::make_cell(tcw_pkg::BLANK_CHAR,
									eff_attr);
							end else begin
								ram_cmd.we    = 1'b1;
								ram_cmd.waddr = base_addr;
								ram_cmd.wdata = tcw_pkg::make_cell(req_q.char_code, eff_attr);
								if (base_col == tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS - 1)) begin
									cur_col_d = '0;
									next_row  = {1'b0, base_row} + 1'b1;
								end else begin
									cur_col_d = base_col + 1'b1;
								end
							end
							if (next_row == (tcw_pkg::ROW_W + 1)'(tcw_pkg::SCREEN_ROWS)) begin
								cur_row_d = tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
								go_scroll = 1'b1;
							end else begin
								cur_row_d = next_row[tcw_pkg::ROW_W-1:0];
							end
						end
					end
					tcw_pkg::REQ_BACKSPACE: begin
						if (cur_col_q != '0) begin
							cur_col_d = cur_col_q - 1'b1;
						end else if (cur_row_q != '0) begin
							cur_col_d = tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS - 1);
							cur_row_d = cur_row_q - 1'b1;
						end
						ram_cmd.we    = 1'b1;
						ram_cmd.waddr = tcw_pkg::cell_addr(cur_row_d, cur_col_d);
						ram_cmd.wdata = tcw_pkg::make_cell(tcw_pkg::BLANK_CHAR, default_attr_q);
					end
					tcw_pkg::REQ_CLEAR: begin
						cur_col_d = '0;
						cur_row_d = '0;
						go_clear  = 1'b1;
					end
					tcw_pkg::REQ_READ: begin
						if (req_q.at_position && off_screen) begin
							fin_oor = 1'b1;
						end else begin
							ram_cmd.re    = 1'b1;
							ram_cmd.raddr = base_addr;
							go_read       = 1'b1;
						end
					end
					default: begin
					end
				endcase
				fin_now = !go_scroll && !go_clear && !go_read;
			end
			ST_READ: begin
				fin_char = ram_rdata[7:0];
				fin_attr = ram_rdata[15:8];
				fin_now  = 1'b1;
			end
			ST_SCROLL: begin
				ram_cmd.re    = 1'b1;
				ram_cmd.raddr = cnt_q;
			end
			ST_BLANK: begin
				if (!cp_valid_s1) begin
					ram_cmd.we    = 1'b1;
					ram_cmd.waddr = blk_addr_q;
					ram_cmd.wdata = tcw_pkg::make_cell(tcw_pkg::BLANK_CHAR, blk_attr_q);
					fin_now       = (blk_addr_q == tcw_pkg::addr_t'(tcw_pkg::CELL_COUNT - 1));
					fin_scr       = scr_q;
				end
			end
			default: begin
			end
		endcase
		if (cp_valid_s1) begin
			ram_cmd.we    = 1'b1;
			ram_cmd.waddr = cp_addr_s1;
			ram_cmd.wdata = ram_rdata;
		end
		fin.cursor_column  = cur_col_d;
		fin.cursor_line    = cur_row_d;
		fin.cell_char      = fin_char;
		fin.cell_attribute = fin_attr;
		fin.out_of_range   = fin_oor;
		fin.scrolled       = fin_scr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			rsp_valid_q    <= 1'b0;
			cur_col_q      <= '0;
			cur_row_q      <= '0;
			cnt_q          <= '0;
			blk_addr_q     <= '0;
			cp_valid_s1    <= 1'b0;
			default_attr_q <= tcw_pkg::DEFAULT_ATTR_RESET;
			fill_attr_q    <= tcw_pkg::FILL_ATTR_RESET;
			error_attr_q   <= tcw_pkg::ERROR_ATTR_RESET;
		end else begin
			cur_col_q   <= cur_col_d;
			cur_row_q   <= cur_row_d;
			cp_valid_s1 <= (state_q == ST_SCROLL);
			cp_addr_s1  <= cnt_q - tcw_pkg::addr_t'(tcw_pkg::SCREEN_COLUMNS);

			if (cfg_we) begin
				case (cfg_index)
					tcw_pkg::CFG_DEFAULT_ATTR: default_attr_q <= cfg_data;
					tcw_pkg::CFG_FILL_ATTR:    fill_attr_q    <= cfg_data;
					tcw_pkg::CFG_ERROR_ATTR:   error_attr_q   <= cfg_data;
					default: begin
					end
				endcase
			end

			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_INIT: begin
					if (blk_addr_q == tcw_pkg::addr_t'(tcw_pkg::CELL_COUNT - 1)) begin
						blk_addr_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						blk_addr_q <= blk_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req_data;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go_scroll) begin
						cnt_q   <= tcw_pkg::addr_t'(tcw_pkg::SCREEN_COLUMNS);
						scr_q   <= 1'b1;
						state_q <= ST_SCROLL;
					end else if (go_clear) begin
						blk_addr_q <= '0;
						blk_attr_q <= default_attr_q;
						scr_q      <= 1'b0;
						state_q    <= ST_BLANK;
					end else if (go_read) begin
						state_q <= ST_READ;
					end
				end
				ST_SCROLL: begin
					if (cnt_q == tcw_pkg::addr_t'(tcw_pkg::CELL_COUNT - 1)) begin
						blk_addr_q <= tcw_pkg::addr_t'(tcw_pkg::CELL_COUNT
							- tcw_pkg::SCREEN_COLUMNS);
						blk_attr_q <= fill_attr_q;
						state_q    <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_BLANK: begin
					if (!cp_valid_s1) begin
						blk_addr_q <= blk_addr_q + 1'b1;
					end
				end
				ST_WAIT_OUT: begin
					if (out_free) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (fin_now) begin
				res_q <= fin;
				if (out_free) begin
					rsp_q       <= fin;
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end else begin
					state_q <= ST_WAIT_OUT;
				end
			end
		end
	end

endmodule
